[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by matrix_inverse_3x3_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[design/minv_pkg.sv]
// ----------------------------------------------------------------------------
// minv_pkg
// Shared constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package minv_pkg;
    localparam int unsigned NUM_ELEM = 9;
    localparam int unsigned DIM      = 3;
    // operand stages in minv_div ahead of the quotient steps
    localparam int          DIV_PREP = 2;
endpackage

[design/matrix_inverse_3x3_top.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)
// s_      | in  | a00 a01 a02 a10 a11 a12 a20 a21 a22, DATA_WIDTH each
// m_      | out | b00 .. b22, DATA_WIDTH each; tuser = singular
//
// One request per cycle sustained unless the output stalls. The pipeline has 5
// cofactor/determinant stages, DATA_WIDTH+3 divider stages (two operand
// stages plus one per quotient bit) and the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall holds every stage. Reset clears all valid bits.
`include "assert_macros.svh"

module matrix_inverse_3x3_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [9*DATA_WIDTH-1:0]   s_tdata,  // a00..a22
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [9*DATA_WIDTH-1:0]   m_tdata,  // b00..b22
    output logic                      m_tuser   // singular
);
    localparam int DW  = DATA_WIDTH;
    localparam int LAT = DW + 1 + minv_pkg::DIV_PREP;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                   c_valid;
    logic [9*DW-1:0]        c_mat;
    logic signed [2*DW:0]   c_cof [9];
    logic signed [3*DW+2:0] c_det;

    minv_cof #(.DW(DW)) u_cof (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid), .in_mat(s_tdata),
        .out_valid(c_valid), .out_mat(c_mat), .out_cof(c_cof), .out_det(c_det)
    );

    // adjugate: output (r,c) takes cofactor (c,r)
    logic [DW-1:0] q [9];
    for (genvar i = 0; i < 9; i++) begin : g_div
        minv_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
            .aclk(aclk), .en(en),
            .cof(c_cof[(i%3)*3 + i/3]), .det(c_det), .q(q[i])
        );
    end

    // delay line for valid, passthrough matrix and singular flag
    logic            v_reg   [LAT];
    logic            z_reg   [LAT];
    logic [9*DW-1:0] m_reg   [LAT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= c_valid;
            for (int k = 1; k < LAT; k++) v_reg[k] <= v_reg[k-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= (c_det == '0);
            m_reg[0] <= c_mat;
            for (int k = 1; k < LAT; k++) begin
                z_reg[k] <= z_reg[k-1];
                m_reg[k] <= m_reg[k-1];
            end
        end
    end

    logic [9*DW-1:0] res;
    always_comb begin
        for (int i = 0; i < 9; i++) res[i*DW +: DW] = q[i];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= v_reg[LAT-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_tuser <= z_reg[LAT-1];
            m_tdata <= z_reg[LAT-1] ? m_reg[LAT-1] : res;
        end
    end

    // hold a waiting result unchanged; accept input whenever the output is free
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_IMPLIES(a_ready_when_free, aclk, aresetn, !m_tvalid, s_tready)
    `ASSERT_IMPLIES(a_flag_known, aclk, aresetn, m_tvalid, !$isunknown(m_tuser))
endmodule

[design/minv_cof.sv]
// ----------------------------------------------------------------------------
// minv_cof
// Cofactor and determinant stages: products, differences, row-0 cofactor expansion.
// ----------------------------------------------------------------------------
module minv_cof #(
    parameter int DW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [9*DW-1:0]      in_mat,
    output logic                 out_valid,
    output logic [9*DW-1:0]      out_mat,
    output logic signed [2*DW:0] out_cof [9],
    output logic signed [3*DW+2:0] out_det
);
    localparam int PW  = 2 * DW;
    localparam int CW  = 2 * DW + 1;
    localparam int DTW = 3 * DW + 3;
    localparam int HPW = 2 * DW + 1;
    localparam int PSW = 2 * DW + 3;

    logic signed [DW-1:0] a [3][3];
    logic signed [PW-1:0] p1_reg [3][3];
    logic signed [PW-1:0] p2_reg [3][3];
    logic [9*DW-1:0]      mat1_reg;
    logic                 v1_reg;
    logic signed [CW-1:0] cof_reg [3][3];
    logic [9*DW-1:0]      mat2_reg;
    logic                 v2_reg;
    logic signed [HPW-1:0] pl_reg [3];
    logic signed [HPW-1:0] ph_reg [3];
    logic signed [CW-1:0]  cof3_reg [3][3];
    logic [9*DW-1:0]       mat3_reg;
    logic                  v3_reg;
    logic signed [PSW-1:0] ls_reg;
    logic signed [PSW-1:0] hs_reg;
    logic signed [CW-1:0]  cof4_reg [3][3];
    logic [9*DW-1:0]       mat4_reg;
    logic                  v4_reg;
    logic signed [DTW-1:0] det_reg;
    logic signed [CW-1:0]  cof5_reg [3][3];
    logic [9*DW-1:0]       mat5_reg;
    logic                  v5_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                a[r][c] = in_mat[(r*3+c)*DW +: DW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: 2x2 minor products
            mat1_reg <= in_mat;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p1_reg[r][c] <= a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3];
                    p2_reg[r][c] <= a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
                end
            end
            mat2_reg <= mat1_reg;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    cof_reg[r][c] <= CW'(p1_reg[r][c]) - CW'(p2_reg[r][c]);
                end
            end
            // det = sum over row 0 of a0c * cof0c; split each cofactor at
            // DW bits so every multiplier stays about DW by DW
            mat3_reg <= mat2_reg;
            cof3_reg <= cof_reg;
            for (int c = 0; c < 3; c++) begin
                pl_reg[c] <= $signed(mat2_reg[c*DW +: DW])
                             * $signed({1'b0, cof_reg[0][c][DW-1:0]});
                ph_reg[c] <= $signed(mat2_reg[c*DW +: DW])
                             * $signed(cof_reg[0][c][CW-1:DW]);
            end
            mat4_reg <= mat3_reg;
            cof4_reg <= cof3_reg;
            ls_reg   <= PSW'(pl_reg[0]) + PSW'(pl_reg[1]) + PSW'(pl_reg[2]);
            hs_reg   <= PSW'(ph_reg[0]) + PSW'(ph_reg[1]) + PSW'(ph_reg[2]);
            mat5_reg <= mat4_reg;
            cof5_reg <= cof4_reg;
            det_reg  <= (DTW'(hs_reg) <<< DW) + DTW'(ls_reg);
        end
    end

    assign out_valid = v5_reg;
    assign out_mat   = mat5_reg;
    assign out_det   = det_reg;
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            out_cof[i] = cof5_reg[i/3][i%3];
        end
    end
endmodule

[design/minv_div.sv]
// ----------------------------------------------------------------------------
// minv_div
// Pipelined signed rounding divider: two operand stages, then one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module minv_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [2*DW:0]   cof,
    input  logic signed [3*DW+2:0] det,
    output logic [DW-1:0]          q
);
    localparam int CW  = 2 * DW + 1;
    localparam int DTW = 3 * DW + 3;
    localparam int QB  = DW + 1;           // magnitude bits kept plus overflow
    localparam int SW  = CW + 2 * FB + 1;
    localparam int NW  = (SW > DTW ? SW : DTW) + 1;
    localparam int RW  = DTW + 1;

    logic [CW-1:0]  cmag_reg;
    logic [DTW-1:0] dmag_reg;
    logic           neg1_reg;
    logic [NW-1:0]  num_reg;
    logic [RW-1:0]  den_reg;
    logic           neg2_reg;
    logic [NW-1:0]  num_hi;
    logic [RW-1:0]  rem0;
    logic           big;
    logic [RW:0]    st      [QB];
    logic [RW-1:0]  rem_reg [QB-1];
    logic [QB-1:0]  n_reg   [QB-1];
    logic [RW-1:0]  d_reg   [QB-1];
    logic [QB-1:0]  q_reg   [QB];
    logic           s_reg   [QB];
    logic           b_reg   [QB];
    logic [QB-1:0]  mag;
    logic [QB-1:0]  lim;

    // one restoring step: {quotient bit, next remainder}
    function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic nbit,
                                             logic [RW-1:0] d);
        logic [RW:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, d}) begin
            return {1'b1, RW'(t - {1'b0, d})};
        end
        return {1'b0, t[RW-1:0]};
    endfunction

    // numerator 2*|C|*2^(2F) + |D|, denominator 2*|D|
    always_ff @(posedge aclk) begin
        if (en) begin
            cmag_reg <= cof[CW-1] ? CW'(-cof) : CW'(cof);
            dmag_reg <= det[DTW-1] ? DTW'(-det) : DTW'(det);
            neg1_reg <= cof[CW-1] ^ det[DTW-1];
            num_reg  <= (NW'(cmag_reg) << (2 * FB + 1)) + NW'(dmag_reg);
            den_reg  <= {dmag_reg, 1'b0};
            neg2_reg <= neg1_reg;
        end
    end

    // quotient of more than QB bits only flags overflow
    assign num_hi = num_reg >> QB;
    assign rem0   = RW'(num_hi);
    assign big    = num_hi >= NW'(den_reg);

    always_comb begin
        st[0] = div_step(rem0, num_reg[QB-1], den_reg);
        for (int k = 1; k < QB; k++) begin
            st[k] = div_step(rem_reg[k-1], n_reg[k-1][QB-1], d_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= st[0][RW-1:0];
            n_reg[0]   <= num_reg[QB-1:0] << 1;
            d_reg[0]   <= den_reg;
            for (int k = 1; k < QB - 1; k++) begin
                rem_reg[k] <= st[k][RW-1:0];
                n_reg[k]   <= n_reg[k-1] << 1;
                d_reg[k]   <= d_reg[k-1];
            end
            q_reg[0] <= QB'(st[0][RW]);
            s_reg[0] <= neg2_reg;
            b_reg[0] <= big;
            for (int k = 1; k < QB; k++) begin
                q_reg[k] <= {q_reg[k-1][QB-2:0], st[k][RW]};
                s_reg[k] <= s_reg[k-1];
                b_reg[k] <= b_reg[k-1];
            end
        end
    end

    assign mag = q_reg[QB-1];
    assign lim = QB'(1) << (DW - 1);
    always_comb begin
        if (!s_reg[QB-1]) begin
            q = (b_reg[QB-1] || mag > lim - QB'(1)) ? DW'(lim - QB'(1)) : DW'(mag);
        end else begin
            q = (b_reg[QB-1] || mag > lim) ? DW'(-lim) : DW'(-mag);
        end
    end
endmodule
